// ===== rtl/nmea_rmc_sentence_parser_unit_assert.svh =====
// Assertion macros shared by the RMC parser RTL.
// Expects clk and arst_n in the scope of every use; no other dependencies.
`ifndef NMEA_RMC_SENTENCE_PARSER_UNIT_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRMC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nrmc_pkg.sv =====
// Package for the RMC sentence parser: sizes, character codes, field numbers,
// conversion constants and the stage structs. No dependencies.
package nrmc_pkg;

	localparam int LINE_MAX    = 128;
	localparam int FRAC_DIGITS = 4;

	// line position counter, holds 0 .. LINE_MAX-1
	localparam int CNT_W = $clog2(LINE_MAX);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX - 1);

	localparam int HDR_LEN = 6;
	localparam int HDR_IW  = $clog2(HDR_LEN);
	localparam logic [CNT_W-1:0] HDR_END = CNT_W'(HDR_LEN);
	localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	// comma-counted field numbers
	localparam int FLD_W = 4;
	localparam logic [FLD_W-1:0] FLD_LAST   = 4'd15;
	localparam logic [FLD_W-1:0] FLD_TIME   = 4'd1;
	localparam logic [FLD_W-1:0] FLD_STATUS = 4'd2;
	localparam logic [FLD_W-1:0] FLD_LAT    = 4'd3;
	localparam logic [FLD_W-1:0] FLD_NS     = 4'd4;
	localparam logic [FLD_W-1:0] FLD_LON    = 4'd5;
	localparam logic [FLD_W-1:0] FLD_EW     = 4'd6;
	localparam logic [FLD_W-1:0] FLD_DATE   = 4'd9;

	// present flags
	localparam int PRES_W = 5;
	localparam int P_TIME  = 0;
	localparam int P_VALID = 1;
	localparam int P_LAT   = 2;
	localparam int P_LON   = 3;
	localparam int P_DATE  = 4;

	// status / hemisphere bits
	localparam int VH_W = 3;
	localparam int VH_A = 0;
	localparam int VH_S = 1;
	localparam int VH_W_BIT = 2;

	typedef enum logic [1:0] {
		KIND_TIME,
		KIND_LAT,
		KIND_LON,
		KIND_DATE
	} kind_t;

	function automatic longint pow10(input int n);
		longint p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	function automatic longint gcd_sub(input longint a, input longint b);
		longint x;
		longint y;
		x = a;
		y = b;
		while (x != y) begin
			if (x > y) begin
				x = x - y;
			end else begin
				y = y - x;
			end
		end
		return x;
	endfunction

	localparam longint FRAC_LIM = pow10(FRAC_DIGITS);
	localparam int FRAC_W = $clog2(FRAC_LIM);
	localparam int FC_W   = $clog2(FRAC_DIGITS + 1);

	typedef logic [FRAC_W-1:0] frac_wt_t [2**FC_W];

	// place value of each fraction digit, padded to FRAC_DIGITS digits
	function automatic frac_wt_t mk_frac_wt();
		frac_wt_t t;
		for (int k = 0; k < 2**FC_W; k++) begin
			t[k] = (k < FRAC_DIGITS) ? FRAC_W'(pow10(FRAC_DIGITS - 1 - k)) : '0;
		end
		return t;
	endfunction

	localparam frac_wt_t FRAC_WT = mk_frac_wt();

	// integer part accumulates as hi (value / 100) and two low digits
	localparam int HI_W = 14;
	localparam logic [HI_W-1:0] HI_SAT  = 14'd9999;
	localparam logic [HI_W-1:0] HI_TRIP = 14'd1000;
	localparam int DIGIT_W = 4;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

	localparam int TD_W  = 20;
	localparam int LAT_W = 28;
	localparam int LON_W = 29;
	localparam int MAG_W = 28;
	localparam int LO_W  = 7;

	localparam int DEG_W   = 8;
	localparam int DEG_CAP = 255;
	localparam longint UDEG_PER_DEG = 1000000;
	localparam longint LAT_LIM = 90000000;
	localparam longint LON_LIM = 180000000;
	localparam logic signed [LAT_W-1:0] LAT_MAX_S = LAT_W'(LAT_LIM);
	localparam logic signed [LAT_W-1:0] LAT_MIN_S = LAT_W'(-LAT_LIM);
	localparam logic signed [LON_W-1:0] LON_MAX_S = LON_W'(LON_LIM);
	localparam logic signed [LON_W-1:0] LON_MIN_S = LON_W'(-LON_LIM);
	localparam logic [TD_W-1:0] TD_SAT = 20'd999999;

	// minutes to microdegrees: udeg = x * 10^6 / (60 * 10^FRAC_DIGITS), reduced
	localparam longint CONV_G   = gcd_sub(UDEG_PER_DEG, 60 * FRAC_LIM);
	localparam longint CONV_NUM = UDEG_PER_DEG / CONV_G;
	localparam longint CONV_DEN = (60 * FRAC_LIM) / CONV_G;
	localparam longint LO_MUL   = FRAC_LIM * CONV_NUM;
	localparam longint Y_MAX    = (100 * FRAC_LIM - 1) * CONV_NUM;
	localparam int Y_W  = $clog2(Y_MAX + 1);
	localparam int SH   = Y_W + $clog2(CONV_DEN) + 1;
	localparam longint RECIP = ((longint'(1) << SH) + CONV_DEN - 1) / CONV_DEN;
	localparam int RC_W = $clog2(RECIP + 1);
	localparam int Q_W  = $clog2(Y_MAX / CONV_DEN + 1);
	localparam int PROD_W = Y_W + RC_W;

	// field finish / line commit event out of the parser
	typedef struct packed {
		logic                 fin;
		logic                 commit;
		kind_t                kind;
		logic [HI_W-1:0]      hi;
		logic [DIGIT_W-1:0]   d1;
		logic [DIGIT_W-1:0]   d0;
		logic [FRAC_W-1:0]    frac;
		logic [PRES_W-1:0]    present;
		logic [VH_W-1:0]      vh;
	} ev_t;

	// after integer rebuild and scaling
	typedef struct packed {
		logic                 fin;
		logic                 commit;
		kind_t                kind;
		logic [TD_W-1:0]      intv;
		logic [MAG_W-1:0]     deg;
		logic [Y_W-1:0]       y;
		logic [PRES_W-1:0]    present;
		logic [VH_W-1:0]      vh;
	} cv_t;

	// after the constant division
	typedef struct packed {
		logic                 fin;
		logic                 commit;
		kind_t                kind;
		logic [TD_W-1:0]      intv;
		logic [MAG_W-1:0]     deg;
		logic [Q_W-1:0]       q;
		logic [PRES_W-1:0]    present;
		logic [VH_W-1:0]      vh;
	} cq_t;

endpackage

// ===== rtl/nrmc_byte_if.sv =====
// Byte stream channel of the RMC parser: valid/ready plus one received byte.
// No dependencies.
interface nrmc_byte_if ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/nrmc_fix_if.sv =====
// Fix record channel of the RMC parser: valid/ready plus the record fields.
// Depends on nrmc_pkg for the field widths.
interface nrmc_fix_if import nrmc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TD_W-1:0]         time_hms;
	logic                    fix_valid;
	logic signed [LAT_W-1:0] latitude_udeg;
	logic signed [LON_W-1:0] longitude_udeg;
	logic [TD_W-1:0]         date_dmy;

	modport source (output valid, output time_hms, output fix_valid, output latitude_udeg,
		output longitude_udeg, output date_dmy, input ready);
	modport sink (input valid, input time_hms, input fix_valid, input latitude_udeg,
		input longitude_udeg, input date_dmy, output ready);
endinterface

// ===== rtl/nrmc_parse.sv =====
// Per-byte line and field parser; emits finish / commit events into stage 1.
// Depends on nrmc_pkg and nrmc_byte_if.
module nrmc_parse import nrmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	nrmc_byte_if.sink  rx,
	input  logic       adv,
	output ev_t        ev_s1
);

	logic               accept;
	logic [7:0]         c;
	logic               is_digit;
	logic [DIGIT_W-1:0] dig;
	logic               fin_ok;
	logic               first;
	kind_t              kind;
	logic [PRES_W-1:0]  fin_bit;
	ev_t                ev_n;

	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               hdr_q, hdr_n;
	logic [FLD_W-1:0]   fld_q, fld_n;
	logic [HI_W-1:0]    hi_q, hi_n;
	logic [DIGIT_W-1:0] d1_q, d1_n;
	logic [DIGIT_W-1:0] d0_q, d0_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [FC_W-1:0]    fcnt_q, fcnt_n;
	logic               infrac_q, infrac_n;
	logic               stop_q, stop_n;
	logic               started_q, started_n;
	logic [PRES_W-1:0]  pres_q, pres_n;
	logic [VH_W-1:0]    vh_q, vh_n;

	assign rx.ready = adv;
	assign accept   = rx.valid && adv;
	assign c        = rx.rx_byte;

	always_comb begin
		is_digit = (c inside {[CH_0:CH_9]});
		dig      = DIGIT_W'(c - CH_0);
		fin_ok   = started_q && (fld_q inside {FLD_TIME, FLD_LAT, FLD_LON, FLD_DATE});
		first    = !started_q;

		case (fld_q)
			FLD_TIME: begin
				kind    = KIND_TIME;
				fin_bit = PRES_W'(1) << P_TIME;
			end
			FLD_LAT: begin
				kind    = KIND_LAT;
				fin_bit = PRES_W'(1) << P_LAT;
			end
			FLD_LON: begin
				kind    = KIND_LON;
				fin_bit = PRES_W'(1) << P_LON;
			end
			FLD_DATE: begin
				kind    = KIND_DATE;
				fin_bit = PRES_W'(1) << P_DATE;
			end
			default: begin
				kind    = KIND_TIME;
				fin_bit = '0;
			end
		endcase

		cnt_n     = cnt_q;
		hdr_n     = hdr_q;
		fld_n     = fld_q;
		hi_n      = hi_q;
		d1_n      = d1_q;
		d0_n      = d0_q;
		frac_n    = frac_q;
		fcnt_n    = fcnt_q;
		infrac_n  = infrac_q;
		stop_n    = stop_q;
		started_n = started_q;
		pres_n    = pres_q;
		vh_n      = vh_q;

		ev_n         = '0;
		ev_n.kind    = kind;
		ev_n.hi      = hi_q;
		ev_n.d1      = d1_q;
		ev_n.d0      = d0_q;
		ev_n.frac    = frac_q;
		ev_n.present = pres_q | (fin_ok ? fin_bit : '0);
		ev_n.vh      = vh_q;

		if (accept) begin
			if (c == CH_LF) begin
				// end of line: commit a matching sentence, then start over
				ev_n.commit = hdr_q && (cnt_q >= HDR_END);
				ev_n.fin    = ev_n.commit && fin_ok;
				cnt_n       = '0;
				hdr_n       = 1'b1;
				fld_n       = '0;
				hi_n        = '0;
				d1_n        = '0;
				d0_n        = '0;
				frac_n      = '0;
				fcnt_n      = '0;
				infrac_n    = 1'b0;
				stop_n      = 1'b0;
				started_n   = 1'b0;
				pres_n      = '0;
				vh_n        = '0;
			end else if (cnt_q < CNT_LAST) begin
				cnt_n = cnt_q + 1'b1;
				if (cnt_q < HDR_END) begin
					if (c != HDR_TEXT[cnt_q[HDR_IW-1:0]]) begin
						hdr_n = 1'b0;
					end
				end else if (hdr_q) begin
					if (c == CH_COMMA) begin
						ev_n.fin  = fin_ok;
						pres_n    = ev_n.present;
						fld_n     = (fld_q == FLD_LAST) ? fld_q : fld_q + 1'b1;
						hi_n      = '0;
						d1_n      = '0;
						d0_n      = '0;
						frac_n    = '0;
						fcnt_n    = '0;
						infrac_n  = 1'b0;
						stop_n    = 1'b0;
						started_n = 1'b0;
					end else begin
						started_n = 1'b1;
						case (fld_q)
							FLD_STATUS: begin
								if (first) begin
									pres_n[P_VALID] = 1'b1;
									vh_n[VH_A]      = (c == CH_A);
								end
							end
							FLD_NS: begin
								if (first && c == CH_S) begin
									vh_n[VH_S] = 1'b1;
								end
							end
							FLD_EW: begin
								if (first && c == CH_W) begin
									vh_n[VH_W_BIT] = 1'b1;
								end
							end
							FLD_TIME, FLD_LAT, FLD_LON, FLD_DATE: begin
								if (!stop_q) begin
									if (is_digit) begin
										if (infrac_q) begin
											// drop digits past the kept precision
											if (fcnt_q < FC_W'(FRAC_DIGITS)) begin
												frac_n = frac_q + FRAC_W'(dig * FRAC_WT[fcnt_q]);
												fcnt_n = fcnt_q + 1'b1;
											end
										end else if (hi_q >= HI_TRIP) begin
											// value reached a million: hold at 999999
											hi_n = HI_SAT;
											d1_n = DIGIT_NINE;
											d0_n = DIGIT_NINE;
										end else begin
											hi_n = HI_W'(hi_q * HI_W'(10)) + HI_W'(d1_q);
											d1_n = d0_q;
											d0_n = dig;
										end
									end else if (c == CH_DOT && !infrac_q) begin
										infrac_n = 1'b1;
									end else begin
										stop_n = 1'b1;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			hdr_q     <= 1'b1;
			fld_q     <= '0;
			hi_q      <= '0;
			d1_q      <= '0;
			d0_q      <= '0;
			frac_q    <= '0;
			fcnt_q    <= '0;
			infrac_q  <= 1'b0;
			stop_q    <= 1'b0;
			started_q <= 1'b0;
			pres_q    <= '0;
			vh_q      <= '0;
			ev_s1     <= '0;
		end else begin
			cnt_q     <= cnt_n;
			hdr_q     <= hdr_n;
			fld_q     <= fld_n;
			hi_q      <= hi_n;
			d1_q      <= d1_n;
			d0_q      <= d0_n;
			frac_q    <= frac_n;
			fcnt_q    <= fcnt_n;
			infrac_q  <= infrac_n;
			stop_q    <= stop_n;
			started_q <= started_n;
			pres_q    <= pres_n;
			vh_q      <= vh_n;
			if (adv) begin
				ev_s1 <= ev_n;
			end
		end
	end

endmodule

// ===== rtl/nrmc_conv.sv =====
// Numeric conversion stages 2 and 3: rebuild integers, scale minutes and
// divide by the reduced constant via a reciprocal multiply. Depends on nrmc_pkg.
module nrmc_conv import nrmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  ev_t  ev_s1,
	output cq_t  cq_s3
);

	logic [LO_W-1:0]   lo;
	logic [DEG_W-1:0]  hi_c;
	logic [PROD_W-1:0] prod;
	cv_t               cv_n, cv_s2;
	cq_t               cq_n;

	always_comb begin
		lo   = LO_W'(ev_s1.d1 * LO_W'(10)) + LO_W'(ev_s1.d0);
		// anything at or past the cap clamps downstream anyway
		hi_c = (ev_s1.hi > HI_W'(DEG_CAP)) ? DEG_W'(DEG_CAP) : DEG_W'(ev_s1.hi);

		cv_n.fin     = ev_s1.fin;
		cv_n.commit  = ev_s1.commit;
		cv_n.kind    = ev_s1.kind;
		cv_n.intv    = TD_W'(ev_s1.hi * TD_W'(100)) + TD_W'(lo);
		cv_n.deg     = MAG_W'(hi_c * MAG_W'(UDEG_PER_DEG));
		cv_n.y       = Y_W'(lo * Y_W'(LO_MUL)) + Y_W'(ev_s1.frac * Y_W'(CONV_NUM));
		cv_n.present = ev_s1.present;
		cv_n.vh      = ev_s1.vh;
	end

	always_comb begin
		prod         = PROD_W'(cv_s2.y) * PROD_W'(RECIP);
		cq_n.fin     = cv_s2.fin;
		cq_n.commit  = cv_s2.commit;
		cq_n.kind    = cv_s2.kind;
		cq_n.intv    = cv_s2.intv;
		cq_n.deg     = cv_s2.deg;
		cq_n.q       = Q_W'(prod >> SH);
		cq_n.present = cv_s2.present;
		cq_n.vh      = cv_s2.vh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s2 <= '0;
			cq_s3 <= '0;
		end else if (adv) begin
			cv_s2 <= cv_n;
			cq_s3 <= cq_n;
		end
	end

endmodule

// ===== rtl/nrmc_commit.sv =====
// Final stage: clamp angles, hold staged and kept fields, drive the fix
// record register. Depends on nrmc_pkg, nrmc_fix_if and the assertion macros.
`include "nmea_rmc_sentence_parser_unit_assert.svh"

module nrmc_commit import nrmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cq_t        cq_s3,
	output logic       hold,
	nrmc_fix_if.source fix
);

	logic [MAG_W-1:0]        mag;
	logic [LAT_W-1:0]        lat_mag;
	logic [LON_W-1:0]        lon_mag;
	logic                    wr;
	logic                    take;

	logic [TD_W-1:0]         st_time_q, st_time_n;
	logic [TD_W-1:0]         st_date_q, st_date_n;
	logic [LAT_W-1:0]        st_lat_q, st_lat_n;
	logic [LON_W-1:0]        st_lon_q, st_lon_n;

	logic [TD_W-1:0]         kept_time_q, kept_time_n;
	logic [TD_W-1:0]         kept_date_q, kept_date_n;
	logic                    kept_valid_q, kept_valid_n;
	logic signed [LAT_W-1:0] kept_lat_q, kept_lat_n;
	logic signed [LON_W-1:0] kept_lon_q, kept_lon_n;
	logic                    out_valid_q;

	// hold the pipe only when a new record would overwrite an untaken one
	assign hold = cq_s3.commit && out_valid_q && !fix.ready;
	assign wr   = cq_s3.fin && !hold;
	assign take = cq_s3.commit && !hold;

	always_comb begin
		mag     = cq_s3.deg + MAG_W'(cq_s3.q);
		lat_mag = (mag > MAG_W'(LAT_LIM)) ? LAT_W'(LAT_LIM) : LAT_W'(mag);
		lon_mag = (mag > MAG_W'(LON_LIM)) ? LON_W'(LON_LIM) : LON_W'(mag);

		st_time_n = st_time_q;
		st_date_n = st_date_q;
		st_lat_n  = st_lat_q;
		st_lon_n  = st_lon_q;
		if (wr) begin
			case (cq_s3.kind)
				KIND_TIME: st_time_n = cq_s3.intv;
				KIND_LAT:  st_lat_n  = lat_mag;
				KIND_LON:  st_lon_n  = lon_mag;
				KIND_DATE: st_date_n = cq_s3.intv;
				default: begin
				end
			endcase
		end

		kept_time_n  = kept_time_q;
		kept_date_n  = kept_date_q;
		kept_valid_n = kept_valid_q;
		kept_lat_n   = kept_lat_q;
		kept_lon_n   = kept_lon_q;
		if (take) begin
			// empty fields keep the previous line's value
			if (cq_s3.present[P_TIME]) begin
				kept_time_n = st_time_n;
			end
			if (cq_s3.present[P_DATE]) begin
				kept_date_n = st_date_n;
			end
			if (cq_s3.present[P_VALID]) begin
				kept_valid_n = cq_s3.vh[VH_A];
			end
			if (cq_s3.present[P_LAT]) begin
				kept_lat_n = cq_s3.vh[VH_S] ? $signed(-st_lat_n) : $signed(st_lat_n);
			end
			if (cq_s3.present[P_LON]) begin
				kept_lon_n = cq_s3.vh[VH_W_BIT] ? $signed(-st_lon_n) : $signed(st_lon_n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_time_q <= '0;
			st_date_q <= '0;
			st_lat_q  <= '0;
			st_lon_q  <= '0;
		end else begin
			st_time_q <= st_time_n;
			st_date_q <= st_date_n;
			st_lat_q  <= st_lat_n;
			st_lon_q  <= st_lon_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_time_q  <= '0;
			kept_date_q  <= '0;
			kept_valid_q <= 1'b0;
			kept_lat_q   <= '0;
			kept_lon_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			kept_time_q  <= kept_time_n;
			kept_date_q  <= kept_date_n;
			kept_valid_q <= kept_valid_n;
			kept_lat_q   <= kept_lat_n;
			kept_lon_q   <= kept_lon_n;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (fix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign fix.valid          = out_valid_q;
	assign fix.time_hms       = kept_time_q;
	assign fix.fix_valid      = kept_valid_q;
	assign fix.latitude_udeg  = kept_lat_q;
	assign fix.longitude_udeg = kept_lon_q;
	assign fix.date_dmy       = kept_date_q;

	`NRMC_ASSERT_IMP(a_lat_range, fix.valid, fix.latitude_udeg <= LAT_MAX_S && fix.latitude_udeg >= LAT_MIN_S, "latitude out of range")
	`NRMC_ASSERT_IMP(a_lon_range, fix.valid, fix.longitude_udeg <= LON_MAX_S && fix.longitude_udeg >= LON_MIN_S, "longitude out of range")
	`NRMC_ASSERT_IMP(a_td_range, fix.valid, fix.time_hms <= TD_SAT && fix.date_dmy <= TD_SAT, "time or date past saturation")
	`NRMC_ASSERT_NXT(a_lat_keep, cq_s3.commit && !cq_s3.present[P_LAT] && !hold, $stable(kept_lat_q), "latitude changed without a latitude field")

endmodule

// ===== rtl/nmea_rmc_sentence_parser_unit.sv =====
// Top level of the NMEA 0183 RMC sentence parser.
// Depends on nrmc_pkg, nrmc_byte_if, nrmc_fix_if, nrmc_parse, nrmc_conv, nrmc_commit.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+-----------
//  rx      | in  | rx_byte[7:0]                                         | valid/ready
//  fix     | out | time_hms, fix_valid, latitude_udeg, longitude_udeg,  | valid/ready
//          |     | date_dmy                                             |
//
// One byte is taken every cycle unless rx is stalled. A fix record becomes valid
// once the newline ending a $GNRMC line has passed in order through the parser
// register, the scale stage, the reciprocal multiply stage and the record register.
// arst_n clears all line state and the kept record to zero; header match resets to one.
// rx stalls only while a finished record sits untaken in the record register and
// the next record has reached the last stage; every other byte flows through.
module nmea_rmc_sentence_parser_unit import nrmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	nrmc_byte_if.sink  rx,
	nrmc_fix_if.source fix
);

	logic hold;
	logic adv;
	ev_t  ev_s1;
	cq_t  cq_s3;

	// the three stages advance together; only the record register can stall them
	assign adv = !hold;

	// track line position, header, field number and numeric accumulators; emit a
	// finish event on each comma ending a non-empty numeric field, and a commit on the newline of a matching line
	nrmc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.adv    (adv),
		.ev_s1  (ev_s1)
	);

	// rebuild time and date integers, turn ddmm.mmmm into degrees * 10^6 plus scaled
	// minutes, then divide the minutes term by its constant with a reciprocal multiply
	nrmc_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ev_s1  (ev_s1),
		.cq_s3  (cq_s3)
	);

	// clamp, stage per-line fields, fold them into the kept record on commit
	// and present the record as one transaction on fix
	nrmc_commit u_commit (
		.clk    (clk),
		.arst_n (arst_n),
		.cq_s3  (cq_s3),
		.hold   (hold),
		.fix    (fix)
	);

endmodule
